### rtl/cdtd_pkg.sv
// Package for the disc track distance estimator.
// Holds the sequencer state type and the fixed arithmetic constants.
// No dependencies.
package cdtd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIN,
        ST_SEC,
        ST_SCALE,
        ST_ROOT,
        ST_DIFF
    } cdtd_state_t;

    localparam int unsigned FRAMES_W = 20;
    localparam int unsigned MULB_W   = 16;
    localparam int unsigned RAD_W    = 36;
    localparam int unsigned ROOT_W   = RAD_W / 2;
    localparam int unsigned REM_W    = ROOT_W + 1;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned DELTA_W  = 15;
    localparam int unsigned ADD_W    = 12;

    localparam logic [MULB_W-1:0] SEC_PER_MIN = MULB_W'(60);
    localparam logic [MULB_W-1:0] FRM_PER_SEC = MULB_W'(75);
    localparam logic [MULB_W-1:0] GEO_SCALE   = MULB_W'(16'hBB3D);
    localparam logic [ADD_W-1:0]  GEO_OFFSET  = ADD_W'(16'h671F >> 3);
    localparam int unsigned       TRACK_SHIFT = 4;
    localparam logic [CNT_W-1:0]  ROOT_LAST   = CNT_W'(ROOT_W - 1);

endpackage

### rtl/cd_track_distance_estimator.sv
// An input is taken only while the sequencer is idle, after the previous result has entered the output
// register. Each time needs three passes through one shared multiply-add unit
// and 18 steps of a two-bit-per-cycle square root unit, run for both times in turn.
// The output register holds a result until it is taken, while the next item runs.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops out_valid.
module cd_track_distance_estimator
    import cdtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [6:0]         from_min,
    input  logic [5:0]         from_sec,
    input  logic [6:0]         from_frame,
    input  logic [6:0]         to_min,
    input  logic [5:0]         to_sec,
    input  logic [6:0]         to_frame,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [14:0] track_delta
);

    cdtd_state_t state_reg, state_next;
    logic                side_reg, side_next;
    logic [6:0]          from_min_reg, from_frame_reg, to_min_reg, to_frame_reg;
    logic [5:0]          from_sec_reg, to_sec_reg;
    logic [FRAMES_W-1:0] acc_reg, acc_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [ROOT_W-1:0]   root_from_reg, root_from_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [DELTA_W-1:0]  delta_reg, delta_next;

    logic                in_xfer;
    logic [6:0]          min_sel, frame_sel;
    logic [5:0]          sec_sel;
    logic [FRAMES_W-1:0] mul_a;
    logic [MULB_W-1:0]   mul_b;
    logic [ADD_W-1:0]    mul_c;
    logic [RAD_W-1:0]    mac;
    logic [REM_W+1:0]    rem_sh, trial;
    logic                take;
    logic [ROOT_W-1:0]   root_step;
    logic [ROOT_W:0]     diff;
    logic [ROOT_W:0]     mag;
    logic [DELTA_W-1:0]  mag_sh;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign track_delta = delta_reg;

    assign min_sel   = side_reg ? to_min_reg   : from_min_reg;
    assign sec_sel   = side_reg ? to_sec_reg   : from_sec_reg;
    assign frame_sel = side_reg ? to_frame_reg : from_frame_reg;

    // Shared multiply-add unit
    always_comb
    begin
        unique case (state_reg)
            ST_MIN:
            begin
                mul_a = FRAMES_W'(min_sel);
                mul_b = SEC_PER_MIN;
                mul_c = ADD_W'(sec_sel);
            end
            ST_SEC:
            begin
                mul_a = acc_reg;
                mul_b = FRM_PER_SEC;
                mul_c = ADD_W'(frame_sel);
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = GEO_SCALE;
                mul_c = GEO_OFFSET;
            end
        endcase
    end

    assign mac = RAD_W'(mul_a * mul_b) + RAD_W'(mul_c);

    // Square root step: two radicand bits per cycle
    assign rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial     = (REM_W+2)'({root_reg, 2'b01});
    assign take      = (rem_sh >= trial);
    assign root_step = {root_reg[ROOT_W-2:0], take};

    assign diff   = {1'b0, root_reg} - {1'b0, root_from_reg};
    assign mag    = diff[ROOT_W] ? ((ROOT_W+1)'(0) - diff) : diff;
    assign mag_sh = DELTA_W'(mag >> TRACK_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            from_min_reg   <= from_min;
            from_sec_reg   <= from_sec;
            from_frame_reg <= from_frame;
            to_min_reg     <= to_min;
            to_sec_reg     <= to_sec;
            to_frame_reg   <= to_frame;
        end
        side_reg      <= side_next;
        acc_reg       <= acc_next;
        rad_reg       <= rad_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        root_from_reg <= root_from_next;
        cnt_reg       <= cnt_next;
        delta_reg     <= delta_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        side_next      = side_reg;
        acc_next       = acc_reg;
        rad_next       = rad_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        root_from_next = root_from_reg;
        cnt_next       = cnt_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    side_next  = 1'b0;
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                acc_next   = FRAMES_W'(mac);
                state_next = ST_SEC;
            end
            ST_SEC:
            begin
                acc_next   = FRAMES_W'(mac);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                rad_next   = mac;
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = ROOT_LAST;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                rem_next  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_next = root_step;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (!side_reg)
                    begin
                        root_from_next = root_step;
                        side_next      = 1'b1;
                        state_next     = ST_MIN;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    delta_next     = diff[ROOT_W] ? (DELTA_W'(0) - mag_sh) : mag_sh;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cdtd_checker.sv
// Port-level checks for the disc track distance estimator.
// Depends on cdtd_pkg; bound to cd_track_distance_estimator below.
module cdtd_checker
    import cdtd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [14:0] track_delta
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(track_delta))
        else $error("stalled result changed or dropped");

    // Drop ready after a transfer while the item is worked
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after input transfer");

    // A new result is produced only while the input side is busy
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // Magnitude stays within the reachable range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (track_delta <= 15'sd10400) && (track_delta >= -15'sd10400))
        else $error("track_delta out of range");

endmodule

bind cd_track_distance_estimator cdtd_checker u_cdtd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .track_delta (track_delta)
);
